/* rtl/lcd_rect_fill_sequencer_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LCD_RECT_FILL_SEQUENCER_UNIT_ASSERT_SVH
`define LCD_RECT_FILL_SEQUENCER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LRFS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lrfs assertion failed");
`define LRFS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lrfs implication failed");
`define LRFS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lrfs next-cycle check failed");
`else
`define LRFS_ASSERT(name, prop)
`define LRFS_ASSERT_IMPL(name, ante, cons)
`define LRFS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* rtl/lrfs_pkg.sv */
// ----------------------------------------------------------------------------
// lrfs_pkg
// Types, command codes and the window byte selector of the fill sequencer.
// ----------------------------------------------------------------------------
package lrfs_pkg;

  localparam int ShortSideDef = 240;
  localparam int LongSideDef  = 320;
  localparam int CoordBitsDef = 9;

  localparam int PosW   = 9;
  localparam int ColorW = 16;
  localparam int ByteW  = 8;
  localparam int ModeW  = 3;
  localparam int StepW  = 5;
  localparam int WideW  = 16;

  localparam logic [ByteW-1:0] CmdCol = 8'h2A;
  localparam logic [ByteW-1:0] CmdRow = 8'h2B;
  localparam logic [ByteW-1:0] CmdMem = 8'h2C;

  localparam logic [ModeW-1:0] ModeReset   = 3'd3;
  localparam logic [ModeW-1:0] ModeNarrowA = 3'd0;
  localparam logic [ModeW-1:0] ModeNarrowB = 3'd2;

  localparam logic KindStart   = 1'b0;
  localparam logic KindAdvance = 1'b1;

  localparam logic [StepW-1:0] StepMemCmd  = 5'd10;
  localparam logic [StepW-1:0] StepPixel   = 5'd11;
  localparam logic [StepW-1:0] StepRestore = 5'd12;
  localparam logic [StepW-1:0] StepFinal   = 5'd22;

  localparam logic [3:0] WinColCmd = 4'd0;
  localparam logic [3:0] WinX1Hi   = 4'd1;
  localparam logic [3:0] WinX1Lo   = 4'd2;
  localparam logic [3:0] WinX2Hi   = 4'd3;
  localparam logic [3:0] WinX2Lo   = 4'd4;
  localparam logic [3:0] WinRowCmd = 4'd5;
  localparam logic [3:0] WinY1Hi   = 4'd6;
  localparam logic [3:0] WinY1Lo   = 4'd7;
  localparam logic [3:0] WinY2Hi   = 4'd8;
  localparam logic [3:0] WinY2Lo   = 4'd9;

  typedef struct packed {
    logic              kind;
    logic [PosW-1:0]   start_x;
    logic [PosW-1:0]   start_y;
    logic [PosW-1:0]   end_x;
    logic [PosW-1:0]   end_y;
    logic [ColorW-1:0] fill_color;
  } lrfs_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_data;
    logic             last;
  } lrfs_res_t;

  typedef struct packed {
    logic [ByteW-1:0] val;
    logic             is_data;
  } lrfs_wbyte_t;

  function automatic lrfs_wbyte_t window_byte(input logic [3:0] pos,
                                              input logic [WideW-1:0] x1,
                                              input logic [WideW-1:0] y1,
                                              input logic [WideW-1:0] x2,
                                              input logic [WideW-1:0] y2);
    lrfs_wbyte_t r;
    r.is_data = 1'b1;
    case (pos)
      WinColCmd: begin
        r.val = CmdCol;
        r.is_data = 1'b0;
      end
      WinX1Hi: r.val = x1[15:8];
      WinX1Lo: r.val = x1[7:0];
      WinX2Hi: r.val = x2[15:8];
      WinX2Lo: r.val = x2[7:0];
      WinRowCmd: begin
        r.val = CmdRow;
        r.is_data = 1'b0;
      end
      WinY1Hi: r.val = y1[15:8];
      WinY1Lo: r.val = y1[7:0];
      WinY2Hi: r.val = y2[15:8];
      WinY2Lo: r.val = y2[7:0];
      default: begin
        r.val = CmdMem;
        r.is_data = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/lrfs_chan_if.sv */
// ----------------------------------------------------------------------------
// lrfs channel interfaces
// Valid/ready channels for request words, output bytes and mode writes.
// ----------------------------------------------------------------------------
interface lrfs_in_if import lrfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [PosW-1:0]   start_x;
  logic [PosW-1:0]   start_y;
  logic [PosW-1:0]   end_x;
  logic [PosW-1:0]   end_y;
  logic [ColorW-1:0] fill_color;

  modport source (output valid, kind, start_x, start_y, end_x, end_y, fill_color,
                  input ready);
  modport sink (input valid, kind, start_x, start_y, end_x, end_y, fill_color,
                output ready);
endinterface

interface lrfs_out_if import lrfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             is_data;
  logic             last;

  modport source (output valid, out_byte, is_data, last, input ready);
  modport sink (input valid, out_byte, is_data, last, output ready);
endinterface

interface lrfs_cfg_if import lrfs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] display_mode;

  modport source (output valid, display_mode, input ready);
  modport sink (input valid, display_mode, output ready);
endinterface

/* rtl/lcd_rect_fill_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// lcd_rect_fill_sequencer_unit
// Rectangle fill byte sequencer for a serial display controller.
// ----------------------------------------------------------------------------
// Channels: in_i takes request words (kind 0 starts a fill with corners and
// color, kind 1 asks for the next byte); out_o gives one byte per advance
// word while a fill runs, with is_data for the D/C line and last on the
// final command of the window restore; cfg_i writes display_mode, always
// ready, and is meant to be written while no fill is running.
// Order: a word is registered in the input register at accept; when the
// core takes it, its byte is computed from the sequence counters and
// registered in the output register, which drives out_o.
// Throughput: one word per cycle unless out_o stalls; the sequence counters
// step once per word and the output register frees in the cycle it is taken.
// Start words and advance words outside a fill give no byte.
// Reset: idle, no fill, display_mode 3, both registers empty.
// Receiver stall: the output register holds its byte, one more word waits
// in the input register, and in_i.ready then drops until out_o moves.
// ----------------------------------------------------------------------------
module lcd_rect_fill_sequencer_unit import lrfs_pkg::*; #(
  parameter int ShortSide = ShortSideDef,
  parameter int LongSide  = LongSideDef,
  parameter int CoordBits = CoordBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lrfs_in_if.sink    in_i,
  lrfs_cfg_if.sink   cfg_i,
  lrfs_out_if.source out_o
);

  logic [ModeW-1:0] mode_q;
  logic             s1_valid;
  lrfs_item_t       s1_item;
  logic             has_res;
  lrfs_res_t        res;
  logic             free;
  logic             take;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.display_mode;
    end
  end

  assign take = s1_valid && (!has_res || free);

  lrfs_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  lrfs_core #(
    .ShortSide (ShortSide),
    .LongSide  (LongSide),
    .CoordBits (CoordBits)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (s1_item),
    .take_i    (take),
    .mode_i    (mode_q),
    .has_res_o (has_res),
    .res_o     (res)
  );

  lrfs_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (take && has_res),
    .res_i  (res),
    .free_o (free),
    .out_o  (out_o)
  );

endmodule

/* rtl/lrfs_in_reg.sv */
// ----------------------------------------------------------------------------
// lrfs_in_reg
// Input register stage holding one request word until the core takes it.
// ----------------------------------------------------------------------------
module lrfs_in_reg import lrfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lrfs_in_if.sink    in_i,
  input  logic       take_i,
  output logic       valid_o,
  output lrfs_item_t item_o
);

  logic       valid_q, valid_d;
  lrfs_item_t item_q;
  logic       accept;

  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind       <= in_i.kind;
      item_q.start_x    <= in_i.start_x;
      item_q.start_y    <= in_i.start_y;
      item_q.end_x      <= in_i.end_x;
      item_q.end_y      <= in_i.end_y;
      item_q.fill_color <= in_i.fill_color;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/lrfs_core.sv */
// ----------------------------------------------------------------------------
// lrfs_core
// Sequence state, corner and color hold, and byte selection for one word.
// ----------------------------------------------------------------------------
module lrfs_core import lrfs_pkg::*; #(
  parameter int ShortSide = ShortSideDef,
  parameter int LongSide  = LongSideDef,
  parameter int CoordBits = CoordBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lrfs_item_t       item_i,
  input  logic             take_i,
  input  logic [ModeW-1:0] mode_i,
  output logic             has_res_o,
  output lrfs_res_t        res_o
);

`include "lcd_rect_fill_sequencer_unit_assert.svh"

  logic                 busy_q, busy_d;
  logic [StepW-1:0]     step_q, step_d;
  logic                 half_q, half_d;
  logic [CoordBits-1:0] col_q, col_d;
  logic [CoordBits-1:0] row_q, row_d;
  logic [CoordBits-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [ColorW-1:0]    color_q;

  logic              is_adv;
  logic              do_step;
  logic              do_load;
  logic              narrow;
  logic              empty;
  logic              col_end;
  logic              row_end;
  logic [WideW-1:0]  wd_m1, ht_m1;
  lrfs_wbyte_t       rect_b, rest_b;

  assign is_adv    = (item_i.kind == KindAdvance);
  assign has_res_o = is_adv && busy_q;
  assign do_step   = take_i && has_res_o;
  assign do_load   = take_i && !is_adv && !busy_q;

  assign narrow  = (mode_i == ModeNarrowA) || (mode_i == ModeNarrowB);
  assign wd_m1   = narrow ? WideW'(ShortSide - 1) : WideW'(LongSide - 1);
  assign ht_m1   = narrow ? WideW'(LongSide - 1) : WideW'(ShortSide - 1);
  assign empty   = (ex_q < sx_q) || (ey_q < sy_q);
  assign col_end = (col_q == (ex_q - sx_q));
  assign row_end = (row_q == (ey_q - sy_q));

  assign rect_b = window_byte(step_q[3:0],
                              WideW'({{WideW{1'b0}}, sx_q}),
                              WideW'({{WideW{1'b0}}, sy_q}),
                              WideW'({{WideW{1'b0}}, ex_q}),
                              WideW'({{WideW{1'b0}}, ey_q}));
  assign rest_b = window_byte(4'(step_q - StepRestore), '0, '0, wd_m1, ht_m1);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    half_d = half_q;
    col_d  = col_q;
    row_d  = row_q;
    res_o  = '0;
    if (step_q < StepPixel) begin
      res_o.out_byte = rect_b.val;
      res_o.is_data  = rect_b.is_data;
      if (step_q == StepMemCmd) begin
        step_d = empty ? StepRestore : StepPixel;
      end else begin
        step_d = step_q + 1'b1;
      end
    end else if (step_q == StepPixel) begin
      res_o.is_data = 1'b1;
      if (!half_q) begin
        res_o.out_byte = color_q[15:8];
        half_d = 1'b1;
      end else begin
        res_o.out_byte = color_q[7:0];
        half_d = 1'b0;
        col_d  = col_q + 1'b1;
        if (col_end) begin
          col_d = '0;
          row_d = row_q + 1'b1;
          if (row_end) begin
            row_d  = '0;
            step_d = StepRestore;
          end
        end
      end
    end else begin
      res_o.out_byte = rest_b.val;
      res_o.is_data  = rest_b.is_data;
      if (step_q >= StepFinal) begin
        res_o.last = 1'b1;
        busy_d = 1'b0;
        step_d = '0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      half_q <= 1'b0;
      col_q  <= '0;
      row_q  <= '0;
    end else if (do_load) begin
      busy_q <= 1'b1;
      step_q <= '0;
      half_q <= 1'b0;
      col_q  <= '0;
      row_q  <= '0;
    end else if (do_step) begin
      busy_q <= busy_d;
      step_q <= step_d;
      half_q <= half_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      sx_q    <= CoordBits'({{CoordBits{1'b0}}, item_i.start_x});
      sy_q    <= CoordBits'({{CoordBits{1'b0}}, item_i.start_y});
      ex_q    <= CoordBits'({{CoordBits{1'b0}}, item_i.end_x});
      ey_q    <= CoordBits'({{CoordBits{1'b0}}, item_i.end_y});
      color_q <= item_i.fill_color;
    end
  end

  `LRFS_ASSERT_IMPL(a_idle_step_zero, !busy_q, step_q == '0 && !half_q)
  `LRFS_ASSERT_IMPL(a_step_range, busy_q, step_q <= StepFinal)
  `LRFS_ASSERT_IMPL(a_half_in_pixels, half_q, step_q == StepPixel)
  `LRFS_ASSERT_NEXT(a_last_ends, do_step && res_o.last, !busy_q)

endmodule

/* rtl/lrfs_out_reg.sv */
// ----------------------------------------------------------------------------
// lrfs_out_reg
// Output register holding one result byte until the receiver takes it.
// ----------------------------------------------------------------------------
module lrfs_out_reg import lrfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  lrfs_res_t  res_i,
  output logic       free_o,
  lrfs_out_if.source out_o
);

  logic      valid_q, valid_d;
  lrfs_res_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.out_byte = res_q.out_byte;
  assign out_o.is_data  = res_q.is_data;
  assign out_o.last     = res_q.last;

endmodule
